/* sv/elr_pkg.sv */
// ---------------------------------------------------------------------------
// elr_pkg - shared types and constants for the LED ring frame generator
// Beat layouts, LED masks, mode codes and the clipped shift helper.
// ---------------------------------------------------------------------------
package elr_pkg;

    // ring geometry and LED word masks (active-high before inversion)
    localparam int          RING_LEDS       = 11;
    localparam int          CENTRE_LED      = 6;
    localparam logic [15:0] IND_MASK        = 16'hFFE0;
    localparam logic [15:0] LEFT_MASK       = 16'hF800;
    localparam logic [15:0] RIGHT_MASK      = 16'h03E0;
    localparam logic [15:0] PWM_MASK        = 16'hFBE0;
    localparam logic [15:0] TOP_BIT         = 16'h8000;
    localparam logic [15:0] ALL_ON          = 16'hFFFF;
    localparam logic [15:0] CENTRE_BIT      = 16'h0400;
    localparam logic [15:0] DETENT_BLUE_BIT = 16'h0001;

    // display mode codes
    localparam logic [1:0] MODE_DOT     = 2'd0;
    localparam logic [1:0] MODE_BAR     = 2'd1;
    localparam logic [1:0] MODE_BAR_PWM = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // remainder < interval <= 65535/11, so 13 bits; times up to 64 frames
    localparam int R_W      = 13;
    localparam int X_W      = R_W + 6;
    localparam int PWM_ON_W = 7;
    localparam int FRAME_W  = 6;

    typedef enum logic [1:0] {
        PWM_NONE,
        PWM_ON_FIRST,
        PWM_OFF_FIRST
    } t_pwm_kind;

    // input beat
    typedef struct packed {
        logic [15:0] position;
        logic [1:0]  mode;
        logic        detent;
        logic [3:0]  encoder_index;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [5:0]  frame_index;
        logic [3:0]  ring_index;
        logic [15:0] led_word;
        logic        status;
        logic        last;
    } t_out_beat;

    // divider -> pattern stage
    typedef struct packed {
        logic [15:0]    whole;
        logic [15:0]    norm;
        logic [R_W-1:0] rem;
        logic [1:0]     mode;
        logic           detent;
        logic [3:0]     ring;
    } t_div_beat;

    // pattern -> frame sequencer
    typedef struct packed {
        logic [15:0]         base;
        logic [15:0]         pwm_bit;
        t_pwm_kind           kind;
        logic [PWM_ON_W-1:0] pwm_on;
        logic                err;
        logic [3:0]          ring;
    } t_pat_beat;

    // right shift that yields zero for a negative or too large amount
    function automatic logic [15:0] shr16(input logic [15:0] v,
                                          input logic signed [17:0] amount);
        logic [15:0] res;
        if (amount < 18'sd0 || amount > 18'sd15) begin
            res = 16'd0;
        end else begin
            res = v >> amount[3:0];
        end
        return res;
    endfunction

endpackage

/* sv/elr_chan_if.sv */
// ---------------------------------------------------------------------------
// elr_chan_if - valid/ready channel
// Carries one payload of type T per beat.
// ---------------------------------------------------------------------------
interface elr_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/elr_div.sv */
// ---------------------------------------------------------------------------
// elr_div - position quotient and remainder by the LED interval
// Three stages: reciprocal multiply, back-multiply, correct and round.
// ---------------------------------------------------------------------------
module elr_div #(
    parameter int POSITION_MAX = 127
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  elr_pkg::t_in_beat   i_beat,
    output logic                o_vld,
    input  logic                i_rdy,
    output elr_pkg::t_div_beat  o_beat
);
    localparam int          IVAL   = POSITION_MAX / elr_pkg::RING_LEDS;
    localparam logic [15:0] IVAL_W = 16'(IVAL);
    localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / IVAL);

    logic               r1_vld, r2_vld, r3_vld;
    logic               rdy1, rdy2, rdy3;
    elr_pkg::t_in_beat  r1_beat, r2_beat;
    logic [47:0]        r1_prod, n1_prod;
    logic [15:0]        r2_q, n2_q;
    logic [31:0]        r2_qi, n2_qi;
    elr_pkg::t_div_beat r3_beat, n3_beat;

    logic [16:0]        r_est, rem17;
    logic               corr, round_up, low_end, full;
    logic [15:0]        q;

    // stall chain
    assign rdy3  = !r3_vld || i_rdy;
    assign rdy2  = !r2_vld || rdy3;
    assign rdy1  = !r1_vld || rdy2;
    assign o_rdy = rdy1;

    // stage 1: estimate quotient by reciprocal, one short at most
    assign n1_prod = {32'd0, i_beat.position} * {16'd0, RECIP};

    // stage 2: multiply the estimate back
    assign n2_q  = r1_prod[47:32];
    assign n2_qi = {16'd0, n2_q} * {16'd0, IVAL_W};

    // stage 3: correct, round, and handle the ends of the range
    always_comb begin
        r_est    = {1'b0, r2_beat.position} - r2_qi[16:0];
        corr     = r_est >= {1'b0, IVAL_W};
        q        = r2_q + {15'd0, corr};
        rem17    = corr ? (r_est - {1'b0, IVAL_W}) : r_est;
        round_up = {rem17, 1'b0} >= {2'b0, IVAL_W};
        low_end  = r2_beat.position <= IVAL_W;
        full     = r2_beat.position == 16'(POSITION_MAX);

        n3_beat.mode   = r2_beat.mode;
        n3_beat.detent = r2_beat.detent;
        n3_beat.ring   = r2_beat.encoder_index;
        if (low_end) begin
            n3_beat.whole = 16'd0;
            n3_beat.norm  = 16'd0;
            n3_beat.rem   = '0;
        end else if (full) begin
            n3_beat.whole = 16'(elr_pkg::RING_LEDS);
            n3_beat.norm  = 16'(elr_pkg::RING_LEDS);
            n3_beat.rem   = '0;
        end else begin
            n3_beat.whole = q;
            n3_beat.norm  = q + {15'd0, round_up};
            n3_beat.rem   = rem17[elr_pkg::R_W-1:0];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_vld;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_beat <= i_beat;
            r1_prod <= n1_prod;
        end
        if (rdy2) begin
            r2_beat <= r1_beat;
            r2_q    <= n2_q;
            r2_qi   <= n2_qi;
        end
        if (rdy3) begin
            r3_beat <= n3_beat;
        end
    end

    assign o_vld  = r3_vld;
    assign o_beat = r3_beat;

endmodule

/* sv/elr_pat.sv */
// ---------------------------------------------------------------------------
// elr_pat - LED pattern and fractional frame count
// Three stages: masks and scaled remainder, reciprocal multiply, correction.
// ---------------------------------------------------------------------------
module elr_pat #(
    parameter int POSITION_MAX      = 127,
    parameter int FRAMES_PER_UPDATE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  elr_pkg::t_div_beat  i_beat,
    output logic                o_vld,
    input  logic                i_rdy,
    output elr_pkg::t_pat_beat  o_beat
);
    localparam int          IVAL  = POSITION_MAX / elr_pkg::RING_LEDS;
    localparam int          X_W   = elr_pkg::X_W;
    localparam int          ON_W  = elr_pkg::PWM_ON_W;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / IVAL);

    logic                   r4_vld, r5_vld, r6_vld;
    logic                   rdy4, rdy5, rdy6;
    elr_pkg::t_pat_beat     r4_pat, n4_pat, r5_pat, r6_pat, n6_pat;
    logic [X_W-1:0]         r4_x, n4_x, r5_x;
    logic [X_W+31:0]        r5_prod, n5_prod;
    logic [ON_W-1:0]        est;
    logic [X_W-1:0]         back, diff;

    logic signed [17:0]     norm_s, whole_s;
    logic                   det, below, above, at_centre;
    logic [15:0]            base, pwm_bit;
    elr_pkg::t_pwm_kind     kind;

    // stall chain
    assign rdy6  = !r6_vld || i_rdy;
    assign rdy5  = !r5_vld || rdy6;
    assign rdy4  = !r4_vld || rdy5;
    assign o_rdy = rdy4;

    // stage 4: static LED masks from the rounded and whole index
    always_comb begin
        norm_s    = $signed({2'b00, i_beat.norm});
        whole_s   = $signed({2'b00, i_beat.whole});
        det       = i_beat.detent;
        below     = i_beat.norm < 16'(elr_pkg::CENTRE_LED);
        above     = i_beat.norm > 16'(elr_pkg::CENTRE_LED);
        at_centre = i_beat.norm == 16'(elr_pkg::CENTRE_LED);
        base      = 16'd0;
        pwm_bit   = 16'd0;
        kind      = elr_pkg::PWM_NONE;

        if (i_beat.mode == elr_pkg::MODE_DOT) begin
            base = elr_pkg::IND_MASK & elr_pkg::shr16(elr_pkg::TOP_BIT, norm_s - 18'sd1);
        end else if (det) begin
            if (below) begin
                base = elr_pkg::shr16(elr_pkg::LEFT_MASK, norm_s - 18'sd1)
                       & elr_pkg::LEFT_MASK;
            end else if (above) begin
                base = elr_pkg::shr16(elr_pkg::LEFT_MASK, norm_s - 18'sd5)
                       & elr_pkg::RIGHT_MASK;
            end
        end else begin
            base = elr_pkg::IND_MASK & ~elr_pkg::shr16(elr_pkg::ALL_ON, norm_s);
        end

        // centre detent: detent LED replaces the middle indicator
        if (det && at_centre) begin
            base = (base & ~elr_pkg::CENTRE_BIT) | elr_pkg::DETENT_BLUE_BIT;
        end

        // fractional LED
        if (i_beat.mode == elr_pkg::MODE_BAR_PWM) begin
            if (det) begin
                if (below) begin
                    pwm_bit = elr_pkg::shr16(elr_pkg::TOP_BIT, whole_s - 18'sd1)
                              & elr_pkg::PWM_MASK;
                    kind    = elr_pkg::PWM_OFF_FIRST;
                end else if (above) begin
                    pwm_bit = elr_pkg::shr16(elr_pkg::TOP_BIT, whole_s) & elr_pkg::PWM_MASK;
                    kind    = elr_pkg::PWM_ON_FIRST;
                end
            end else begin
                pwm_bit = elr_pkg::shr16(elr_pkg::TOP_BIT, whole_s) & elr_pkg::PWM_MASK;
                kind    = elr_pkg::PWM_ON_FIRST;
            end
        end

        n4_pat.base    = base;
        n4_pat.pwm_bit = pwm_bit;
        n4_pat.kind    = kind;
        n4_pat.pwm_on  = '0;
        n4_pat.err     = i_beat.mode == elr_pkg::MODE_INVALID;
        n4_pat.ring    = i_beat.ring;
    end

    assign n4_x = X_W'(i_beat.rem) * X_W'(FRAMES_PER_UPDATE);

    // stage 5: frame count estimate by reciprocal
    assign n5_prod = {32'd0, r4_x} * {{X_W{1'b0}}, RECIP};

    // stage 6: multiply back and correct by one
    always_comb begin
        est    = r5_prod[32 +: ON_W];
        back   = X_W'(est) * X_W'(IVAL);
        diff   = r5_x - back;
        n6_pat = r5_pat;
        n6_pat.pwm_on = est + ON_W'(diff >= X_W'(IVAL));
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            if (rdy4) r4_vld <= i_vld;
            if (rdy5) r5_vld <= r4_vld;
            if (rdy6) r6_vld <= r5_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_pat <= n4_pat;
            r4_x   <= n4_x;
        end
        if (rdy5) begin
            r5_pat  <= r4_pat;
            r5_x    <= r4_x;
            r5_prod <= n5_prod;
        end
        if (rdy6) begin
            r6_pat <= n6_pat;
        end
    end

    assign o_vld  = r6_vld;
    assign o_beat = r6_pat;

endmodule

/* sv/elr_frame_gen.sv */
// ---------------------------------------------------------------------------
// elr_frame_gen - per-frame LED word sequencer
// Walks one pattern's PWM frames into an output reg, one beat per cycle unless stalled.
// ---------------------------------------------------------------------------
module elr_frame_gen #(
    parameter int FRAMES_PER_UPDATE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_limit,
    input  logic               i_vld,
    output logic               o_rdy,
    input  elr_pkg::t_pat_beat i_pat,
    output logic               o_vld,
    input  logic               i_rdy,
    output elr_pkg::t_out_beat o_beat
);
    localparam int                  FW         = elr_pkg::FRAME_W;
    localparam logic [FW-1:0]       FRAME_LAST = FW'(FRAMES_PER_UPDATE - 1);

    logic               r_out_vld;
    logic [FW-1:0]      r_frame;
    elr_pkg::t_out_beat r_beat, n_beat;
    logic               load, frame_last, dark, early, lit;
    logic [15:0]        word;

    assign load       = !r_out_vld || i_rdy;
    assign frame_last = i_pat.err || (r_frame == FRAME_LAST);
    assign o_rdy      = load && frame_last;

    // word for the current frame
    always_comb begin
        dark  = {2'b00, r_frame} > i_limit;
        early = {1'b0, r_frame} < i_pat.pwm_on;
        lit   = (i_pat.kind == elr_pkg::PWM_ON_FIRST) ? early : !early;
        word  = i_pat.base;
        if (dark) begin
            word = 16'd0;
        end else if (i_pat.kind != elr_pkg::PWM_NONE) begin
            word = lit ? (i_pat.base | i_pat.pwm_bit) : (i_pat.base & ~i_pat.pwm_bit);
        end

        n_beat.frame_index = i_pat.err ? 6'd0 : 6'(r_frame);
        n_beat.ring_index  = i_pat.ring;
        n_beat.led_word    = i_pat.err ? 16'd0 : ~word;
        n_beat.status      = i_pat.err;
        n_beat.last        = frame_last;
    end

    // frame counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_frame   <= '0;
        end else if (load) begin
            r_out_vld <= i_vld;
            if (i_vld) begin
                r_frame <= frame_last ? '0 : r_frame + 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_beat = r_beat;

endmodule

/* sv/encoder_led_ring_frame_gen.sv */
// ---------------------------------------------------------------------------
// encoder_led_ring_frame_gen - PWM frame generator for an 11-LED encoder ring
//
// i_in  : one beat per encoder update (position, mode, detent, index).
// o_out : FRAMES_PER_UPDATE beats per update, frame 0 first, last set on the
//         final frame; an invalid mode gives a single beat with status set.
// i_cfg : brightness limit write, always ready; write only while idle.
// An input beat passes three divider stages, three pattern stages and the
// output register before its first frame appears.
// Throughput: the frame sequencer issues one word per cycle unless o_out
// stalls. Updates overlap in the six-stage pipeline so frames stream
// without gaps.
// Reset clears all valids and sets the brightness limit to 255.
// When o_out stalls, the output beat holds and the pipeline fills up, then
// i_in.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module encoder_led_ring_frame_gen #(
    parameter int POSITION_MAX      = 127,
    parameter int FRAMES_PER_UPDATE = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    elr_chan_if.sink      i_in,
    elr_chan_if.source    o_out,
    elr_chan_if.sink      i_cfg
);
    logic               cfg_wr;
    logic [7:0]         r_bright;
    logic               div_vld, div_rdy, pat_vld, pat_rdy;
    elr_pkg::t_div_beat div_beat;
    elr_pkg::t_pat_beat pat_beat;

    // brightness register
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= 8'd255;
        end else if (cfg_wr) begin
            r_bright <= i_cfg.data;
        end
    end

    elr_div #(
        .POSITION_MAX (POSITION_MAX)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_beat  (i_in.data),
        .o_vld   (div_vld),
        .i_rdy   (div_rdy),
        .o_beat  (div_beat)
    );

    elr_pat #(
        .POSITION_MAX      (POSITION_MAX),
        .FRAMES_PER_UPDATE (FRAMES_PER_UPDATE)
    ) u_pat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .o_rdy   (div_rdy),
        .i_beat  (div_beat),
        .o_vld   (pat_vld),
        .i_rdy   (pat_rdy),
        .o_beat  (pat_beat)
    );

    elr_frame_gen #(
        .FRAMES_PER_UPDATE (FRAMES_PER_UPDATE)
    ) u_frame_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_bright),
        .i_vld   (pat_vld),
        .o_rdy   (pat_rdy),
        .i_pat   (pat_beat),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_beat  (o_out.data)
    );

endmodule

/* sv/elr_checker.sv */
// ---------------------------------------------------------------------------
// elr_checker - port-level checks on the frame output
// Bound to the top level; looks at the output channel only.
// ---------------------------------------------------------------------------
module elr_checker #(
    parameter int FRAMES_PER_UPDATE = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input elr_pkg::t_out_beat i_beat
);
    localparam logic [5:0] FRAME_LAST = 6'(FRAMES_PER_UPDATE - 1);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_beat))
        else $error("output beat changed under stall");

    // error beat is a lone frame 0 with a blank word
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_beat.status |->
            i_beat.last && i_beat.led_word == 16'd0 && i_beat.frame_index == 6'd0)
        else $error("malformed error beat");

    // frames of one update follow in order
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_beat.last |=>
            !i_valid || i_beat.frame_index == 6'($past(i_beat.frame_index) + 6'd1))
        else $error("frame index skipped");

    // frame range, last flag and RGB bits dark on normal beats
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_beat.status |->
            i_beat.frame_index <= FRAME_LAST && i_beat.led_word[4:2] == 3'b111 &&
            i_beat.last == (i_beat.frame_index == FRAME_LAST))
        else $error("bad frame beat");

endmodule

bind encoder_led_ring_frame_gen elr_checker #(
    .FRAMES_PER_UPDATE (FRAMES_PER_UPDATE)
) u_elr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_beat  (o_out.data)
);
